// File: rtl/core/lpba_pkg.sv
// shared types and constants of the lidar point to box assigner
package lpba_pkg;

  localparam int MAX_BOXES_DEF  = 16;
  localparam int PIXEL_BITS_DEF = 13;

  localparam logic [2:0] ST_REJECTED = 3'd0;
  localparam logic [2:0] ST_OFF_IMG  = 3'd1;
  localparam logic [2:0] ST_NO_BOX   = 3'd2;
  localparam logic [2:0] ST_ASSIGNED = 3'd3;
  localparam logic [2:0] ST_LOADED   = 3'd4;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_SKEW     = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_COLUMNS  = 3'd5;
  localparam logic [2:0] REG_ROWS     = 3'd6;
  localparam logic [2:0] REG_BOXES    = 3'd7;

  localparam logic OP_LOAD = 1'b0;

  // numerator width: 24x20 products plus sums
  localparam int NUM_W = 47;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  box_slot;
    logic [12:0] box_left;
    logic [12:0] box_right;
    logic [12:0] box_top;
    logic [12:0] box_bottom;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic        point_finite;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  box_index;
    logic signed [23:0] pixel_u;
    logic signed [23:0] pixel_v;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_SCAN, S_DONE
  } state_t;

endpackage

// File: rtl/core/lpba_serial_div.sv
// radix-2 restoring divider for two numerators sharing one divisor, one bit a cycle
module lpba_serial_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [lpba_pkg::NUM_W-1:0] num_a,
  input  logic signed [lpba_pkg::NUM_W-1:0] num_b,
  input  logic [18:0] den,
  output logic done,
  output logic signed [23:0] quo_a,
  output logic signed [23:0] quo_b
);
  import lpba_pkg::*;

  localparam int MAG_W = NUM_W;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] qa, qb;
  logic [19:0] ra, rb;
  logic        neg_a, neg_b;
  logic [CNT_W-1:0] cnt;
  logic        run;

  logic [20:0] ta, tb;
  logic [MAG_W:0] fa, fb;
  logic signed [MAG_W+1:0] sa, sb;

  // trial subtract of the shifted remainder
  always_comb begin
    ta = {ra, qa[MAG_W-1]} - {2'b00, den};
    tb = {rb, qb[MAG_W-1]} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(MAG_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude bits shift out at the top into the remainder, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      neg_a <= num_a[NUM_W-1];
      neg_b <= num_b[NUM_W-1];
      qa <= num_a[NUM_W-1] ? MAG_W'(-num_a) : MAG_W'(num_a);
      qb <= num_b[NUM_W-1] ? MAG_W'(-num_b) : MAG_W'(num_b);
      ra <= '0;
      rb <= '0;
    end else if (run) begin
      if (!ta[20]) begin
        ra <= ta[19:0];
        qa <= {qa[MAG_W-2:0], 1'b1};
      end else begin
        ra <= {ra[18:0], qa[MAG_W-1]};
        qa <= {qa[MAG_W-2:0], 1'b0};
      end
      if (!tb[20]) begin
        rb <= tb[19:0];
        qb <= {qb[MAG_W-2:0], 1'b1};
      end else begin
        rb <= {rb[18:0], qb[MAG_W-1]};
        qb <= {qb[MAG_W-2:0], 1'b0};
      end
    end
  end

  // sign and saturate
  always_comb begin
    fa = {1'b0, qa};
    fb = {1'b0, qb};
    sa = neg_a ? -$signed({1'b0, fa}) : $signed({1'b0, fa});
    sb = neg_b ? -$signed({1'b0, fb}) : $signed({1'b0, fb});
    if (sa > $signed((MAG_W+2)'(8388607))) quo_a = 24'sd8388607;
    else if (sa < -$signed((MAG_W+2)'(8388608))) quo_a = -24'sd8388608;
    else quo_a = sa[23:0];
    if (sb > $signed((MAG_W+2)'(8388607))) quo_b = 24'sd8388607;
    else if (sb < -$signed((MAG_W+2)'(8388608))) quo_b = -24'sd8388608;
    else quo_b = sb[23:0];
  end

endmodule

// File: rtl/core/lidar_point_to_box_assigner.sv
// top level: point projection, bounds test and box table scan
// a box load or a rejected point goes from idle straight to done; other points pass
// through the multiply, divide, scan and done states, the scan ending at the first
// matching box or after every searched box
// throughput: one request at a time, the next is taken in the cycle after done
// receiver cannot stall; synchronous reset restores config and state, not the box table
module lidar_point_to_box_assigner #(
  parameter int MAX_BOXES  = lpba_pkg::MAX_BOXES_DEF,
  parameter int PIXEL_BITS = lpba_pkg::PIXEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  lpba_pkg::request_t request,
  output logic done,
  output lpba_pkg::result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import lpba_pkg::*;

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  // configuration registers
  logic [23:0] focal_x, focal_y;
  logic signed [23:0] skew;
  logic [20:0] center_x, center_y;
  logic [13:0] image_columns, image_rows;
  logic [4:0]  boxes_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 24'd256000;
      focal_y <= 24'd256000;
      skew <= '0;
      center_x <= 21'd163840;
      center_y <= 21'd122880;
      image_columns <= 14'd1280;
      image_rows <= 14'd960;
      boxes_in_use <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x <= cfg_data;
        REG_FOCAL_Y:  focal_y <= cfg_data;
        REG_SKEW:     skew <= $signed(cfg_data);
        REG_CENTER_X: center_x <= cfg_data[20:0];
        REG_CENTER_Y: center_y <= cfg_data[20:0];
        REG_COLUMNS:  image_columns <= cfg_data[13:0];
        REG_ROWS:     image_rows <= cfg_data[13:0];
        REG_BOXES:    boxes_in_use <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // box table memory
  logic [4*PIXEL_BITS-1:0] box_mem [MAX_BOXES];
  logic [4*PIXEL_BITS-1:0] box_rd;
  logic [IDX_W-1:0] scan_idx;

  always_ff @(posedge clk) begin
    if (start && !busy && request.opcode == OP_LOAD
        && 32'(request.box_slot) < MAX_BOXES) begin
      box_mem[IDX_W'(request.box_slot)] <= {PIXEL_BITS'(request.box_left),
        PIXEL_BITS'(request.box_right), PIXEL_BITS'(request.box_top),
        PIXEL_BITS'(request.box_bottom)};
    end
    box_rd <= box_mem[scan_idx];
  end

  // sequencer
  state_t state, state_next;
  request_t req;
  logic [2:0] mul_step;
  logic signed [NUM_W-1:0] acc_u, acc_v, prod;
  logic signed [23:0] pu, pv;
  logic signed [23:0] du, dv;
  logic [CNT_W-1:0] scan_left, scan_n;
  logic scan_pend;
  logic [2:0] status;
  logic [3:0] box_index;
  logic hit;
  logic div_start, div_done;

  always_comb begin
    if (32'(boxes_in_use) < MAX_BOXES) scan_n = CNT_W'(boxes_in_use);
    else scan_n = CNT_W'(MAX_BOXES);
  end

  // one multiplier shared over five partial products
  always_comb begin
    case (mul_step)
      3'd0: prod = NUM_W'($signed({1'b0, focal_x}) * req.point_x);
      3'd1: prod = NUM_W'(skew * req.point_y);
      3'd2: prod = NUM_W'($signed({1'b0, center_x}) * req.point_z);
      3'd3: prod = NUM_W'($signed({1'b0, focal_y}) * req.point_y);
      default: prod = NUM_W'($signed({1'b0, center_y}) * req.point_z);
    endcase
  end

  lpba_serial_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num_a(acc_u), .num_b(acc_v), .den(req.point_z[18:0]),
    .done(div_done), .quo_a(du), .quo_b(dv)
  );

  logic accept, reject_pt;
  assign accept = start && !busy;
  assign reject_pt = !request.point_finite || request.point_z <= 20'sd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        if (request.opcode == OP_LOAD || reject_pt) state_next = S_DONE;
        else state_next = S_MUL;
      end
      S_MUL:  if (mul_step == 3'd5) state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_SCAN;
      S_SCAN: if (hit || status != ST_NO_BOX || (scan_left == '0 && !scan_pend))
                state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    result.status = status;
    result.box_index = box_index;
    result.pixel_u = pu;
    result.pixel_v = pv;
    div_start = (state == S_MUL) && (mul_step == 3'd5);
  end

  // containment test of the box read last cycle
  logic [PIXEL_BITS-1:0] bl, br, bt, bb;
  always_comb begin
    {bl, br, bt, bb} = box_rd;
    hit = scan_pend && status == ST_NO_BOX
      && pu >= $signed({1'b0, bl, 8'd0}) && pu <= $signed({1'b0, br, 8'd0})
      && pv >= $signed({1'b0, bt, 8'd0}) && pv <= $signed({1'b0, bb, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath
  logic [IDX_W-1:0] pend_idx;
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (accept) begin
        req <= request;
        mul_step <= '0;
        acc_u <= '0;
        acc_v <= '0;
        box_index <= '0;
        pu <= '0;
        pv <= '0;
        status <= (request.opcode == OP_LOAD) ? ST_LOADED : ST_REJECTED;
      end
      S_MUL: begin
        mul_step <= mul_step + 3'd1;
        if (mul_step < 3'd3) acc_u <= acc_u + prod;
        else if (mul_step < 3'd5) acc_v <= acc_v + prod;
      end
      S_DIV: if (div_done) begin
        pu <= du;
        pv <= dv;
        scan_idx <= '0;
        scan_left <= scan_n;
        scan_pend <= 1'b0;
        if (du < 0 || du >= $signed({2'b00, image_columns, 8'd0})
            || dv < 0 || dv >= $signed({2'b00, image_rows, 8'd0}))
          status <= ST_OFF_IMG;
        else status <= ST_NO_BOX;
      end
      S_SCAN: begin
        if (hit) begin
          status <= ST_ASSIGNED;
          box_index <= 4'(pend_idx);
        end
        pend_idx <= scan_idx;
        scan_pend <= (scan_left != '0);
        if (scan_left != '0) begin
          scan_left <= scan_left - 1'b1;
          scan_idx <= scan_idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: tb/tb.sv
// self-checking bench for the lidar point to box assigner
module tb;
  import lpba_pkg::*;

  localparam int SLOTS = 16;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t request = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_FOCAL_X;
  logic [23:0] cfg_data = '0;

  lidar_point_to_box_assigner dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of registers and box table
  logic [23:0] fx, fy;
  logic signed [23:0] sk;
  logic [20:0] cx, cy;
  logic [13:0] cols, rows;
  logic [4:0] nbox;
  logic [12:0] bl[SLOTS], br[SLOTS], bt[SLOTS], bb[SLOTS];

  request_t pending[$];
  result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit sending = 0;
  int burst = 0, gap = 0;
  logic busy_q = 1'b0;

  // append one request to the send queue
  task automatic queue_req(request_t r);
    pending.insert(pending.size(), r);
  endtask

  function automatic longint clamp_q(longint num, longint den);
    longint q;
    q = num / den;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q;
  endfunction

  // expected result of one request, updating the shadow table
  function automatic result_t classify(request_t r);
    result_t o;
    longint x, y, z, u, v;
    int n;
    o = '0;
    if (r.opcode == OP_LOAD) begin
      bl[r.box_slot] = r.box_left;
      br[r.box_slot] = r.box_right;
      bt[r.box_slot] = r.box_top;
      bb[r.box_slot] = r.box_bottom;
      o.status = ST_LOADED;
      return o;
    end
    x = r.point_x;
    y = r.point_y;
    z = r.point_z;
    if (!r.point_finite || z <= 1) begin
      o.status = ST_REJECTED;
      return o;
    end
    u = clamp_q(longint'(fx) * x + longint'(sk) * y + longint'(cx) * z, z);
    v = clamp_q(longint'(fy) * y + longint'(cy) * z, z);
    o.pixel_u = u[23:0];
    o.pixel_v = v[23:0];
    if (u < 0 || u >= longint'(cols) * 256 || v < 0 || v >= longint'(rows) * 256) begin
      o.status = ST_OFF_IMG;
      return o;
    end
    o.status = ST_NO_BOX;
    n = (nbox > SLOTS) ? SLOTS : nbox;
    for (int i = 0; i < n; i++) begin
      if (u >= longint'(bl[i]) * 256 && u <= longint'(br[i]) * 256 &&
          v >= longint'(bt[i]) * 256 && v <= longint'(bb[i]) * 256) begin
        o.status = ST_ASSIGNED;
        o.box_index = i[3:0];
        break;
      end
    end
    return o;
  endfunction

  // register write through the config channel, idle only
  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 24'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FOCAL_X: fx = 24'(val);
      REG_FOCAL_Y: fy = 24'(val);
      REG_SKEW: sk = 24'(val);
      REG_CENTER_X: cx = 21'(val);
      REG_CENTER_Y: cy = 21'(val);
      REG_COLUMNS: cols = 14'(val);
      REG_ROWS: rows = 14'(val);
      default: nbox = 5'(val);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic request_t box_req(int slot, int l, int rr, int t, int b);
    request_t q;
    q = '0;
    q.opcode = OP_LOAD;
    q.box_slot = 4'(slot);
    q.box_left = 13'(l);
    q.box_right = 13'(rr);
    q.box_top = 13'(t);
    q.box_bottom = 13'(b);
    q.point_x = 20'($urandom);
    q.point_y = 20'($urandom);
    q.point_z = 20'($urandom);
    q.point_finite = 1'($urandom);
    return q;
  endfunction

  function automatic request_t point_req(int x, int y, int z, bit fin);
    request_t q;
    q = '0;
    q.opcode = ~OP_LOAD;
    q.box_slot = 4'($urandom);
    q.box_left = 13'($urandom);
    q.box_right = 13'($urandom);
    q.box_top = 13'($urandom);
    q.box_bottom = 13'($urandom);
    q.point_x = 20'(x);
    q.point_y = 20'(y);
    q.point_z = 20'(z);
    q.point_finite = fin;
    return q;
  endfunction

  // random point aimed mostly near the image, sometimes anywhere
  function automatic request_t rand_point();
    int z, x, y;
    if ($urandom_range(0, 9) == 0)
      return point_req($urandom, $urandom, $urandom, $urandom_range(0, 7) != 0);
    z = $urandom_range(2, 60000);
    if ($urandom_range(0, 15) == 0) z = $urandom_range(0, 1) ? 2 : -$urandom_range(0, 5);
    x = $signed($urandom_range(0, 2 * z)) - z;
    y = $signed($urandom_range(0, 2 * z)) - z;
    return point_req(x, y, z, $urandom_range(0, 19) != 0);
  endfunction

  // waits until every queued request has been sent and answered
  task automatic drain();
    while (pending.size() != 0 || sending || expected_results.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // driver: bursts and gaps, request changes on falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_q) begin
        sending = 0;
      end
      if (!sending || (start && !busy_q)) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pending.size() != 0) begin
          request <= pending.pop_front();
          start <= 1'b1;
          sending = 1;
          if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end else burst--;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // acceptance seen at the rising edge
  always @(posedge clk) begin
    busy_q <= busy;
    if (!rst && start && !busy)
      expected_results.insert(expected_results.size(), classify(request));
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d", result.status);
        errors++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (e.status != result.status) begin
          $error("status expected %0d got %0d", e.status, result.status); errors++;
        end
        if (e.box_index != result.box_index) begin
          $error("box_index expected %0d got %0d", e.box_index, result.box_index); errors++;
        end
        if (e.pixel_u != result.pixel_u) begin
          $error("pixel_u expected %0d got %0d", e.pixel_u, result.pixel_u); errors++;
        end
        if (e.pixel_v != result.pixel_v) begin
          $error("pixel_v expected %0d got %0d", e.pixel_v, result.pixel_v); errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // fill every box slot with random boxes, biased to be reachable
  task automatic load_boxes(int span);
    int l, t;
    for (int i = 0; i < SLOTS; i++) begin
      l = $urandom_range(0, span);
      t = $urandom_range(0, span);
      if ($urandom_range(0, 7) == 0)
        queue_req(box_req(i, $urandom, $urandom, $urandom, $urandom));
      else
        queue_req(box_req(i, l, l + $urandom_range(0, span), t,
                          t + $urandom_range(0, span)));
    end
  endtask

  initial begin
    fx = 256000; fy = 256000; sk = 0; cx = 163840; cy = 122880;
    cols = 1280; rows = 960; nbox = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: loads, rejects, extremes
    queue_req(box_req(0, 0, 8191, 0, 8191));
    queue_req(box_req(15, 8191, 0, 8191, 0));
    for (int i = 1; i < 15; i++) queue_req(box_req(i, 600, 700, 400, 500));
    queue_req(point_req(0, 0, 1000, 0));
    queue_req(point_req(0, 0, 1, 1));
    queue_req(point_req(0, 0, -524288, 1));
    queue_req(point_req(524287, 524287, 2, 1));
    queue_req(point_req(-524288, -524288, 2, 1));
    queue_req(point_req(0, 0, 524287, 1));
    queue_req(point_req(100, 100, 1000, 1));
    drain();

    write_reg(REG_BOXES, 16);
    queue_req(point_req(0, 0, 1000, 1));
    queue_req(point_req(-1000, -1000, 1000, 1));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_FOCAL_X, 'hFFFFFF); write_reg(REG_FOCAL_Y, 'hFFFFFF);
          write_reg(REG_SKEW, 'h7FFFFF); write_reg(REG_CENTER_X, 'h1FFFFF);
          write_reg(REG_CENTER_Y, 'h1FFFFF); write_reg(REG_COLUMNS, 8192);
          write_reg(REG_ROWS, 8192); write_reg(REG_BOXES, 31);
        end
        1: begin
          write_reg(REG_FOCAL_X, 0); write_reg(REG_FOCAL_Y, 0);
          write_reg(REG_SKEW, 'h800000); write_reg(REG_CENTER_X, 0);
          write_reg(REG_CENTER_Y, 0); write_reg(REG_COLUMNS, 1);
          write_reg(REG_ROWS, 1); write_reg(REG_BOXES, 0);
        end
        2: begin
          write_reg(REG_COLUMNS, 0); write_reg(REG_ROWS, 0);
          write_reg(REG_FOCAL_X, 256000); write_reg(REG_BOXES, 16);
        end
        default: begin
          write_reg(REG_FOCAL_X, $urandom_range(1000, 400000));
          write_reg(REG_FOCAL_Y, $urandom_range(1000, 400000));
          write_reg(REG_SKEW, $urandom_range(0, 3) == 0 ? $urandom : 0);
          write_reg(REG_CENTER_X, $urandom_range(0, 300000));
          write_reg(REG_CENTER_Y, $urandom_range(0, 300000));
          write_reg(REG_COLUMNS, $urandom_range(1, 3000));
          write_reg(REG_ROWS, $urandom_range(1, 3000));
          write_reg(REG_BOXES, $urandom_range(0, 20));
        end
      endcase
      load_boxes(phase < 3 ? 4000 : 600);
      for (int k = 0; k < 190; k++) begin
        if ($urandom_range(0, 9) == 0)
          queue_req(box_req($urandom, $urandom_range(0, 1500), $urandom_range(0, 3000),
                            $urandom_range(0, 1500), $urandom_range(0, 3000)));
        else queue_req(rand_point());
      end
      drain();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
